// File: hdl/arrt_pkg.sv
// Shared types and constants for the address range region table.
// No dependencies; compiled first.
package arrt_pkg;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_REMOVE  = 3'd1;
    localparam logic [2:0] ACT_LOOKUP  = 3'd2;
    localparam logic [2:0] ACT_NEXT    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    localparam logic [2:0] MODE_DEFAULT = 3'd1;

    typedef enum logic [3:0] {
        ST_NOT_FOUND = 4'd0,
        ST_EXACT     = 4'd1,
        ST_INCLUDED  = 4'd2,
        ST_FOUND     = 4'd3,
        ST_ADDED     = 4'd4,
        ST_DUPLICATE = 4'd5,
        ST_FULL      = 4'd6,
        ST_REMOVED   = 4'd7,
        ST_ABSENT    = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [63:0] asked_length;
        logic [63:0] workspace_id;
        logic [2:0]  access_mode;
        logic [63:0] phys_addr;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{64'd0, 64'd0, 64'd0, 64'd0, MODE_DEFAULT, 64'd0};

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] address;
        logic [63:0] length;
        logic [63:0] asked_length;
        logic [63:0] workspace_id;
        logic [2:0]  access_mode;
        logic [63:0] phys_addr;
    } t_req;

    typedef struct packed {
        t_status status;
        t_entry  hit;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

// File: hdl/arrt_req_if.sv
// Request channel: valid/ready plus one table operation.
// No dependencies.
interface arrt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] address;
    logic [63:0] length;
    logic [63:0] asked_length;
    logic [63:0] workspace_id;
    logic [2:0]  access_mode;
    logic [63:0] phys_addr;

    modport source (output valid, action, address, length, asked_length,
                    workspace_id, access_mode, phys_addr, input ready);
    modport sink   (input valid, action, address, length, asked_length,
                    workspace_id, access_mode, phys_addr, output ready);
endinterface

// File: hdl/arrt_rsp_if.sv
// Response channel: valid/ready plus status and region fields.
// No dependencies.
interface arrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [63:0] hit_base;
    logic [63:0] hit_length;
    logic [63:0] hit_asked_length;
    logic [63:0] hit_workspace_id;
    logic [2:0]  hit_access_mode;
    logic [63:0] hit_phys_addr;

    modport source (output valid, status, hit_base, hit_length, hit_asked_length,
                    hit_workspace_id, hit_access_mode, hit_phys_addr, input ready);
    modport sink   (input valid, status, hit_base, hit_length, hit_asked_length,
                    hit_workspace_id, hit_access_mode, hit_phys_addr, output ready);
endinterface

// File: hdl/arrt_datapath.sv
// Region table storage, sequential base scan, result formation and table update.
// Depends on arrt_pkg.
module arrt_datapath import arrt_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    input  t_req     i_req_data,
    output t_rsp     o_rsp_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    t_req          r_req;
    logic [CW-1:0] r_idx;
    logic          r_exact;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_walk;
    t_entry        r_slot [ENTRIES];
    t_rsp          r_rsp;

    // scan: stop at the first base >= probe, or at the end of the used prefix
    logic   idx_in;
    t_entry scan_e;
    logic   scan_hit;
    logic   scan_stop;

    assign idx_in    = r_idx < r_cnt;
    assign scan_e    = r_slot[r_idx[IW-1:0]];
    assign scan_hit  = idx_in && (scan_e.base == r_req.address);
    assign scan_stop = !idx_in || (scan_e.base >= r_req.address);
    assign o_stat.scan_done = scan_stop;

    logic [CW-1:0] w_start;
    logic          walk_ok;
    logic [CW-1:0] sel_lk;
    logic [CW-1:0] e_idx;
    t_entry        e;
    t_entry        new_e;
    logic [63:0]   off;
    logic          incl;
    logic          span_ok;
    logic          full;
    logic          do_ins;
    logic          do_rem;
    t_rsp          n_rsp;

    always_comb begin
        w_start = (r_req.action == ACT_RESTART) ? '0 : r_walk;
        walk_ok = w_start < r_cnt;
        // not exact: probe > 0, so the scan passed slot 0 and r_idx >= 1
        sel_lk  = r_exact ? r_idx : r_idx - 1'b1;
        case (r_req.action)
            ACT_LOOKUP:           e_idx = sel_lk;
            ACT_NEXT, ACT_RESTART: e_idx = w_start;
            default:              e_idx = r_idx;
        endcase
        e       = r_slot[e_idx[IW-1:0]];
        new_e   = '{r_req.address, r_req.length, r_req.asked_length,
                    r_req.workspace_id, r_req.access_mode, r_req.phys_addr};
        off     = r_req.address - e.base;
        incl    = off < e.length;
        span_ok = (r_req.length <= e.length) && (off <= e.length - r_req.length);
        full    = r_cnt == CW'(ENTRIES);
        do_ins  = (r_req.action == ACT_ADD) && !r_exact && !full;
        do_rem  = (r_req.action == ACT_REMOVE) && (r_req.address != 64'd0) && r_exact;

        n_rsp.status = ST_NOT_FOUND;
        n_rsp.hit    = '0;
        case (r_req.action)
            ACT_ADD: begin
                if (r_exact) begin
                    n_rsp.status = ST_DUPLICATE;
                    n_rsp.hit    = e;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_ADDED;
                    n_rsp.hit    = new_e;
                end
            end
            ACT_REMOVE: begin
                if (do_rem) begin
                    n_rsp.status = ST_REMOVED;
                    n_rsp.hit    = e;
                end else begin
                    n_rsp.status = ST_ABSENT;
                end
            end
            ACT_LOOKUP: begin
                if (r_exact || incl) begin
                    if (r_req.length != 64'd0) begin
                        if (span_ok) begin
                            n_rsp.status = ST_FOUND;
                            n_rsp.hit    = e;
                        end
                    end else begin
                        n_rsp.status = r_exact ? ST_EXACT : ST_INCLUDED;
                        n_rsp.hit    = e;
                    end
                end
            end
            ACT_NEXT, ACT_RESTART: begin
                if (walk_ok) begin
                    n_rsp.status = ST_FOUND;
                    n_rsp.hit    = e;
                end
            end
            default: begin
                n_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_data;
            r_idx   <= '0;
            r_exact <= 1'b0;
        end else if (i_cmd.scan) begin
            if (scan_stop) begin
                r_exact <= scan_hit;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= CW'(1);
            r_walk <= '0;
        end else if (i_cmd.commit) begin
            if (r_req.action == ACT_ADD) begin
                r_walk <= '0;
            end else if (do_rem) begin
                r_walk <= '0;
            end else if ((r_req.action == ACT_NEXT || r_req.action == ACT_RESTART)
                         && walk_ok) begin
                r_walk <= w_start + 1'b1;
            end else if (r_req.action == ACT_RESTART) begin
                r_walk <= '0;
            end
            if (do_ins) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rem) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // each slot takes its neighbor on insert (shift up) or remove (shift down)
    for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
        localparam logic [CW-1:0] G = CW'(g);
        t_entry prev_e;
        t_entry next_e;
        if (g > 0) begin : g_prev
            assign prev_e = r_slot[g-1];
        end else begin : g_noprev
            assign prev_e = ENTRY_RESET;
        end
        if (g < ENTRIES - 1) begin : g_next
            assign next_e = r_slot[g+1];
        end else begin : g_nonext
            assign next_e = ENTRY_RESET;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot[g] <= ENTRY_RESET;
            end else if (i_cmd.commit) begin
                if (do_ins) begin
                    if (G == r_idx) begin
                        r_slot[g] <= new_e;
                    end else if (G > r_idx && G <= r_cnt) begin
                        r_slot[g] <= prev_e;
                    end
                end else if (do_rem) begin
                    if (G >= r_idx && (CW'(g + 1) < r_cnt) && (g < ENTRIES - 1)) begin
                        r_slot[g] <= next_e;
                    end
                end
            end
        end
    end

    assign o_rsp_data = r_rsp;

endmodule

// File: hdl/arrt_ctrl.sv
// Sequencer: accept, scan, finish; owns both handshakes.
// Depends on arrt_pkg.
module arrt_ctrl import arrt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// File: hdl/address_range_region_table.sv
// Sorted table of memory regions (the user keeps them non-overlapping; the block
// itself does not enforce it) with add, remove, lookup and ordered walk.
// Depends on arrt_pkg, arrt_req_if, arrt_rsp_if, arrt_ctrl, arrt_datapath.
//
// i_req carries one operation per transfer; o_rsp returns exactly one result
// per operation, in order. One operation is in flight at a time.
// An operation takes an accept step, a scan over the stored regions with base below
// the address (at most the region count) and one slot more, and a finish step.
// The scan reads one slot per cycle from the sorted table.
// The result sits in an output register; the next operation is accepted and
// scanned while it waits. If the receiver stalls, the finish step holds until
// the previous result is taken.
// Reset (i_rst_n low, synchronous) leaves one null region at base 0, clears
// the walk position and drops any pending result.
module address_range_region_table import arrt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input logic     i_clk,
    input logic     i_rst_n,
    arrt_req_if.sink   i_req,
    arrt_rsp_if.source o_rsp
);
    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_req     req_data;
    t_rsp     rsp_data;

    assign req_data = '{i_req.action, i_req.address, i_req.length, i_req.asked_length,
                        i_req.workspace_id, i_req.access_mode, i_req.phys_addr};

    arrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    arrt_datapath #(.ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_data (req_data),
        .o_rsp_data (rsp_data)
    );

    assign o_rsp.status           = rsp_data.status;
    assign o_rsp.hit_base         = rsp_data.hit.base;
    assign o_rsp.hit_length       = rsp_data.hit.length;
    assign o_rsp.hit_asked_length = rsp_data.hit.asked_length;
    assign o_rsp.hit_workspace_id = rsp_data.hit.workspace_id;
    assign o_rsp.hit_access_mode  = rsp_data.hit.access_mode;
    assign o_rsp.hit_phys_addr    = rsp_data.hit.phys_addr;

endmodule
